@@ hw/rtl/jss_pkg.sv @@
// jss_pkg: shared types and constants for the jacobi sweep scaling factor unit
// holds the request/response word structs and the divider command/status structs
// no dependencies
`default_nettype none

package jss_pkg;

   localparam int DATA_W    = 32;
   localparam int DIFF_W    = DATA_W + 1;
   localparam int ACC_W     = 64;
   localparam int SMALL_W   = 16;
   localparam int DIV_LOW_W = 32;
   localparam int DIV_CNT_W = 6;

   // step counts for the two kinds of division
   localparam logic [DIV_CNT_W-1:0] ELEM_STEPS   = DIV_CNT_W'(32);
   localparam logic [DIV_CNT_W-1:0] FACTOR_STEPS = DIV_CNT_W'(31);

   localparam logic signed [DATA_W-1:0] SAT32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0]  SAT64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0]  SAT64_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // input word
   typedef struct packed {
      logic signed [DATA_W-1:0] rhs_value;
      logic signed [DATA_W-1:0] solution_value;
      logic signed [DATA_W-1:0] product_value;
      logic signed [DATA_W-1:0] diagonal_value;
      logic                     last_element;
   } jss_req_type;

   // result word
   typedef struct packed {
      logic signed [DATA_W-1:0] updated_solution;
      logic                     zero_diagonal;
      logic                     factor_valid;
      logic signed [DATA_W-1:0] scaling_factor;
   } jss_rsp_type;

   // divider command: start, initial partial remainder, divisor, low dividend bits, step count
   typedef struct packed {
      logic                 start;
      logic [ACC_W-1:0]     rem_init;
      logic [ACC_W-1:0]     divisor;
      logic [DIV_LOW_W-1:0] low_bits;
      logic [DIV_CNT_W-1:0] steps;
   } div_cmd_type;

   // divider status
   typedef struct packed {
      logic                 done;
      logic                 overflow;
      logic [DIV_LOW_W-1:0] quotient;
   } div_stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/jss_div_unit.sv @@
// jss_div_unit: shared radix-2 restoring divider, one quotient bit per cycle
// depends on jss_pkg (div_cmd_type, div_stat_type, widths)
`default_nettype none

module jss_div_unit
   import jss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_cmd_type  div_cmd,
   output div_stat_type div_stat
);

   logic [ACC_W-1:0]     rem_ff, rem_in;
   logic [ACC_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_LOW_W-1:0] low_ff, low_in;
   logic [DIV_LOW_W-1:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 ovf_ff, ovf_in;
   logic                 chk_ff, chk_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;

   logic [ACC_W:0] trial;
   logic [ACC_W:0] trial_sub;
   logic           take;

   // one trial subtraction per step
   always_comb begin
      trial     = {rem_ff, low_ff[DIV_LOW_W-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      take      = (trial >= {1'b0, dvs_ff});
   end

   // sequencer: load, overflow check, then one bit a cycle
   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      chk_in  = chk_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_cmd.start) begin
         rem_in = div_cmd.rem_init;
         dvs_in = div_cmd.divisor;
         low_in = div_cmd.low_bits;
         quo_in = '0;
         cnt_in = div_cmd.steps;
         ovf_in = 1'b0;
         chk_in = 1'b1;
         run_in = 1'b0;
      end else if (chk_ff) begin
         // quotient too wide when the initial remainder reaches the divisor
         chk_in = 1'b0;
         ovf_in = (rem_ff >= dvs_ff);
         if (rem_ff >= dvs_ff) begin
            done_in = 1'b1;
         end else begin
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         rem_in = take ? trial_sub[ACC_W-1:0] : trial[ACC_W-1:0];
         low_in = {low_ff[DIV_LOW_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_LOW_W-2:0], take};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff  <= 1'b0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         chk_ff  <= chk_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      ovf_ff <= ovf_in;
   end

   assign div_stat.done     = done_ff;
   assign div_stat.overflow = ovf_ff;
   assign div_stat.quotient = quo_ff;

endmodule

`default_nettype wire

@@ hw/rtl/jacobi_sweep_scaling_factor_unit.sv @@
// jacobi_sweep_scaling_factor_unit: point-jacobi update with scaling-factor reduction
// depends on jss_pkg and jss_div_unit
//
// Usage:
//   req channel (valid/ready) carries one vector element per word: b, x, Ax, D
//   and a last-element mark, all signed fixed point with FRAC_BITS fraction bits.
//   rsp channel (valid/ready) returns one word per request: x + (b - Ax)/D,
//   the zero-diagonal flag and, on the last element, the scaling factor
//   sum(b*x) / stabilized sum(Ax*x).
//   csr_write_en/csr_write_data write small_value; write only while idle.
// Sequence:
//   one word is in flight at a time; req_ready is high only while idle.
//   an ordinary element passes from accept through the multiply/accumulate states
//   MULN, MULD and ACCD on one shared 32x32 multiplier, the divider check and its
//   32 quotient bits, EWAIT seeing done and the EFIN update, then OUT.
//   the last element adds a second pass through the same divider (FSTB, FSET,
//   FWAIT with 31 quotient bits, FFIN). a zero diagonal skips the element division;
//   a quotient that overflows ends its division right after the check cycle.
//   the next word can be taken in the cycle after the rsp word leaves, so a new
//   element is accepted only once the previous one has fully left.
// Reset and stall:
//   synchronous reset clears both sums, sets small_value to 1 and returns to
//   idle. a stalled rsp word holds until rsp_ready; no new word is taken meanwhile.
`default_nettype none

module jacobi_sweep_scaling_factor_unit
   import jss_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  jss_req_type        req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output jss_rsp_type        rsp_data,
   input  logic               csr_write_en,
   input  logic [SMALL_W-1:0] csr_write_data
);

   localparam int EDIV_W = DIFF_W + FRAC_BITS;
   localparam int FDIV_W = ACC_W + FRAC_BITS;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_MULN  = 11'b000_0000_0010,
      S_MULD  = 11'b000_0000_0100,
      S_ACCD  = 11'b000_0000_1000,
      S_EWAIT = 11'b000_0001_0000,
      S_EFIN  = 11'b000_0010_0000,
      S_FSTB  = 11'b000_0100_0000,
      S_FSET  = 11'b000_1000_0000,
      S_FWAIT = 11'b001_0000_0000,
      S_FFIN  = 11'b010_0000_0000,
      S_OUT   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   jss_req_type               word_ff, word_in;
   logic [SMALL_W-1:0]        small_ff, small_in;
   logic signed [ACC_W-1:0]   num_ff, num_in;
   logic signed [ACC_W-1:0]   den_ff, den_in;
   logic signed [ACC_W-1:0]   prod_ff, prod_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic                      eneg_ff, eneg_in;
   logic                      fneg_ff, fneg_in;
   logic                      fzero_ff, fzero_in;
   logic signed [DATA_W-1:0]  upd_ff, upd_in;
   logic signed [DATA_W-1:0]  fac_ff, fac_in;

   div_cmd_type  div_cmd;
   div_stat_type div_stat;

   logic signed [DATA_W-1:0]  mul_a;
   logic signed [ACC_W-1:0]   mul_p;
   logic                      diag_zero;
   logic [DIFF_W-1:0]         diff_mag;
   logic [DATA_W-1:0]         diag_mag;
   logic [EDIV_W-1:0]         ediv;
   logic [ACC_W-1:0]          stab;
   logic signed [ACC_W-1:0]   den_stab;
   logic [ACC_W-1:0]          num_mag;
   logic [ACC_W-1:0]          den_mag;
   logic [FDIV_W-1:0]         fdiv;
   logic [DIFF_W-1:0]         q_ext;
   logic signed [DIFF_W:0]    q_signed;
   logic signed [DIFF_W+1:0]  upd_sum;
   logic signed [DATA_W-1:0]  upd_sat;

   // 64-bit saturating add
   function automatic logic signed [ACC_W-1:0] sat_add64(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic signed [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? SAT64_MIN : SAT64_MAX;
      end
      return s[ACC_W-1:0];
   endfunction

   // shared multiplier: b*x first, then Ax*x
   always_comb begin
      mul_a = (state_ff == S_MULN) ? word_ff.rhs_value : word_ff.product_value;
      mul_p = ACC_W'($signed(mul_a) * $signed(word_ff.solution_value));
   end

   // element divider operands: |b - Ax| << FRAC_BITS over |D|
   always_comb begin
      diag_zero = (word_ff.diagonal_value == '0);
      diff_mag  = diff_ff[DIFF_W-1] ? DIFF_W'(-diff_ff) : DIFF_W'(diff_ff);
      diag_mag  = word_ff.diagonal_value[DATA_W-1] ? DATA_W'(-word_ff.diagonal_value)
                                                   : DATA_W'(word_ff.diagonal_value);
      ediv      = {diff_mag, {FRAC_BITS{1'b0}}};
   end

   // denominator stabilizing and factor divider operands
   always_comb begin
      stab     = ACC_W'({small_ff, {FRAC_BITS{1'b0}}});
      den_stab = den_ff[ACC_W-1] ? sat_add64(den_ff, -$signed(stab))
                                 : sat_add64(den_ff, $signed(stab));
      num_mag  = num_ff[ACC_W-1] ? ACC_W'(-num_ff) : ACC_W'(num_ff);
      den_mag  = den_ff[ACC_W-1] ? ACC_W'(-den_ff) : ACC_W'(den_ff);
      fdiv     = {num_mag, {FRAC_BITS{1'b0}}};
   end

   // element result: x plus signed quotient, saturated
   always_comb begin
      q_ext    = div_stat.overflow ? {1'b1, {DATA_W{1'b0}}} : {1'b0, div_stat.quotient};
      q_signed = eneg_ff ? -$signed({1'b0, q_ext}) : $signed({1'b0, q_ext});
      upd_sum  = $signed({{3{word_ff.solution_value[DATA_W-1]}}, word_ff.solution_value})
                 + $signed({q_signed[DIFF_W], q_signed});
      if (!upd_sum[DIFF_W+1] && (upd_sum[DIFF_W:DATA_W-1] != '0)) begin
         upd_sat = SAT32_MAX;
      end else if (upd_sum[DIFF_W+1] && (upd_sum[DIFF_W:DATA_W-1] != '1)) begin
         upd_sat = SAT32_MIN;
      end else begin
         upd_sat = upd_sum[DATA_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      word_in  = word_ff;
      small_in = csr_write_en ? csr_write_data : small_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      prod_in  = prod_ff;
      diff_in  = diff_ff;
      eneg_in  = eneg_ff;
      fneg_in  = fneg_ff;
      fzero_in = fzero_ff;
      upd_in   = upd_ff;
      fac_in   = fac_ff;
      div_cmd  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               word_in  = req_data;
               state_in = S_MULN;
            end
         end
         S_MULN: begin
            prod_in  = mul_p;
            diff_in  = DIFF_W'($signed(word_ff.rhs_value))
                       - DIFF_W'($signed(word_ff.product_value));
            state_in = S_MULD;
         end
         S_MULD: begin
            prod_in  = mul_p;
            num_in   = sat_add64(num_ff, prod_ff);
            eneg_in  = diff_ff[DIFF_W-1] != word_ff.diagonal_value[DATA_W-1];
            state_in = S_ACCD;
         end
         S_ACCD: begin
            den_in = sat_add64(den_ff, prod_ff);
            if (diag_zero) begin
               state_in = S_EFIN;
            end else begin
               div_cmd.start    = 1'b1;
               div_cmd.rem_init = ACC_W'(ediv[EDIV_W-1:DIV_LOW_W]);
               div_cmd.divisor  = ACC_W'(diag_mag);
               div_cmd.low_bits = ediv[DIV_LOW_W-1:0];
               div_cmd.steps    = ELEM_STEPS;
               state_in         = S_EWAIT;
            end
         end
         S_EWAIT: begin
            if (div_stat.done) begin
               state_in = S_EFIN;
            end
         end
         S_EFIN: begin
            upd_in   = diag_zero ? word_ff.solution_value : upd_sat;
            fac_in   = '0;
            state_in = word_ff.last_element ? S_FSTB : S_OUT;
         end
         S_FSTB: begin
            den_in   = den_stab;
            state_in = S_FSET;
         end
         S_FSET: begin
            fneg_in          = num_ff[ACC_W-1] != den_ff[ACC_W-1];
            fzero_in         = (num_ff == '0) && (den_ff == '0);
            div_cmd.start    = 1'b1;
            div_cmd.rem_init = ACC_W'(fdiv[FDIV_W-1:DIV_LOW_W-1]);
            div_cmd.divisor  = den_mag;
            div_cmd.low_bits = {fdiv[DIV_LOW_W-2:0], 1'b0};
            div_cmd.steps    = FACTOR_STEPS;
            state_in         = S_FWAIT;
         end
         S_FWAIT: begin
            if (div_stat.done) begin
               state_in = S_FFIN;
            end
         end
         S_FFIN: begin
            if (fzero_ff) begin
               fac_in = '0;
            end else if (div_stat.overflow) begin
               fac_in = fneg_ff ? SAT32_MIN : SAT32_MAX;
            end else begin
               fac_in = fneg_ff ? -$signed(div_stat.quotient) : $signed(div_stat.quotient);
            end
            num_in   = '0;
            den_in   = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state and sums
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         small_ff <= SMALL_W'(1);
         num_ff   <= '0;
         den_ff   <= '0;
      end else begin
         state_ff <= state_in;
         small_ff <= small_in;
         num_ff   <= num_in;
         den_ff   <= den_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      prod_ff  <= prod_in;
      diff_ff  <= diff_in;
      eneg_ff  <= eneg_in;
      fneg_ff  <= fneg_in;
      fzero_ff <= fzero_in;
      upd_ff   <= upd_in;
      fac_ff   <= fac_in;
   end

   jss_div_unit u_div (
      .clock    (clock),
      .reset    (reset),
      .div_cmd  (div_cmd),
      .div_stat (div_stat)
   );

   // handshake and result word
   assign req_ready                 = (state_ff == S_IDLE);
   assign rsp_valid                 = (state_ff == S_OUT);
   assign rsp_data.updated_solution = upd_ff;
   assign rsp_data.zero_diagonal    = diag_zero;
   assign rsp_data.factor_valid     = word_ff.last_element;
   assign rsp_data.scaling_factor   = fac_ff;

   // a result and a new request never overlap
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");

   // divider finishes only while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_EWAIT || state_ff == S_FWAIT))
      else $error("divider done outside a wait state");

   // sums cleared after the factor is formed
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FFIN) |=> (num_ff == '0 && den_ff == '0))
      else $error("sums not cleared after last element");

   // zero diagonal passes x through
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_diagonal)
         |-> (rsp_data.updated_solution == word_ff.solution_value))
      else $error("zero diagonal did not pass x through");

   // no factor outside the last element
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.factor_valid) |-> (rsp_data.scaling_factor == '0))
      else $error("scaling factor nonzero on a non-last element");

endmodule

`default_nettype wire
